// ===== hw/rtl/shsp_pkg.sv =====
package shsp_pkg;

   // default state widths
   localparam int unsigned POSITION_WIDTH_DEF = 32;
   localparam int unsigned TIME_WIDTH_DEF     = 32;

   // fixed field widths
   localparam int unsigned OP_WIDTH        = 3;
   localparam int unsigned FIELD_WIDTH     = 32;
   localparam int unsigned COIL_WIDTH      = 4;
   localparam int unsigned PHASE_WIDTH     = 3;
   localparam int unsigned MODULUS_WIDTH   = 31;
   localparam int unsigned PERIOD_WIDTH    = 20;
   localparam int unsigned JITTER_WIDTH    = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 31;

   // operation codes
   localparam logic [OP_WIDTH-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_RELATIVE = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_ABSOLUTE = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_STOP     = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_SET_LOC  = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRAP_MODULUS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_PERIOD  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JITTER       = 2'd2;

   // register reset values
   localparam logic [MODULUS_WIDTH-1:0] WRAP_MODULUS_RST = 31'd4096;
   localparam logic [PERIOD_WIDTH-1:0]  STEP_PERIOD_RST  = 20'd2000;
   localparam logic [JITTER_WIDTH-1:0]  JITTER_RST       = 16'd0;

   // half-step coil patterns, indexed by phase
   localparam logic [COIL_WIDTH-1:0] COIL_TABLE [8] = '{
      4'b0001, 4'b1001, 4'b1000, 4'b1100, 4'b0100, 4'b0110, 4'b0010, 4'b0011
   };

   // remainder unit status
   typedef struct packed {
      logic                     done;
      logic                     neg;
      logic [MODULUS_WIDTH-1:0] remainder;
   } shsp_div_status_type;

endpackage

// ===== hw/rtl/shsp_div_unit.sv =====
module shsp_div_unit
   import shsp_pkg::*;
#(
   parameter int unsigned DividendWidth = FIELD_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DividendWidth-1:0] dividend,
   input  logic [MODULUS_WIDTH-1:0] divisor,
   output shsp_div_status_type      status
);

   localparam int unsigned CountWidth = $clog2(DividendWidth + 1);

   logic [DividendWidth-1:0] mag_ff, mag_in;
   logic [MODULUS_WIDTH-1:0] rem_ff, rem_in;
   logic [MODULUS_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CountWidth-1:0]    cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic                     prep_ff, prep_in;
   logic                     run_ff, run_in;
   logic                     done_ff, done_in;
   logic [MODULUS_WIDTH:0]   shifted;
   logic [MODULUS_WIDTH:0]   trial;

   // one remainder bit a cycle, restoring
   assign shifted = {rem_ff, mag_ff[DividendWidth-1]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      prep_in = 1'b0;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in  = dividend;
         neg_in  = dividend[DividendWidth-1];
         dsr_in  = divisor;
         rem_in  = '0;
         prep_in = 1'b1;
         run_in  = 1'b0;
      end else if (prep_ff) begin
         // magnitude of the signed dividend
         mag_in = neg_ff ? (DividendWidth'(0) - mag_ff) : mag_ff;
         cnt_in = CountWidth'(DividendWidth);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = trial[MODULUS_WIDTH] ? shifted[MODULUS_WIDTH-1:0]
                                       : trial[MODULUS_WIDTH-1:0];
         mag_in = {mag_ff[DividendWidth-2:0], 1'b0};
         cnt_in = cnt_ff - CountWidth'(1);
         if (cnt_ff == CountWidth'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         prep_ff <= prep_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign status.done      = done_ff;
   assign status.neg       = neg_ff;
   assign status.remainder = rem_ff;

endmodule

// ===== hw/rtl/stepper_half_step_positioner_core.sv =====
// sequence, accept to result beat: tick, relative move, stop, unused codes,
// absolute move or set location without modulus go S_EXEC then S_DONE; a tick that steps adds S_WRAP;
// under a modulus absolute move and set location also pass S_DIV, S_FIX and S_APPLY,
// waiting in S_DIV on the bit-serial remainder unit
// one item at a time, no overlap; req_stall drops once the result is registered
// reset (synchronous, active high): motor state zero, modulus 4096, period 2000 us, jitter 0
module stepper_half_step_positioner_core
   import shsp_pkg::*;
#(
   parameter int unsigned PositionWidth = POSITION_WIDTH_DEF,
   parameter int unsigned TimeWidth     = TIME_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_WIDTH-1:0]        req_operation,
   input  logic signed [FIELD_WIDTH-1:0] req_amount,
   input  logic [FIELD_WIDTH-1:0]     req_now_us,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [COIL_WIDTH-1:0]      rsp_coil_drive,
   output logic signed [FIELD_WIDTH-1:0] rsp_position,
   output logic signed [FIELD_WIDTH-1:0] rsp_steps_remaining,
   output logic                       rsp_is_moving,
   output logic                       rsp_step_taken,
   // register write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // the remainder unit works on the wider of the position and the amount field
   localparam int unsigned DivWidth   = (PositionWidth > FIELD_WIDTH) ? PositionWidth
                                                                      : FIELD_WIDTH;
   // room for a signed position plus or minus the modulus
   localparam int unsigned ArithWidth = DivWidth + 2;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_FIX   = 3'd3;
   localparam logic [2:0] S_APPLY = 3'd4;
   localparam logic [2:0] S_WRAP  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   // captured request beat
   logic [OP_WIDTH-1:0]           op_ff;
   logic signed [FIELD_WIDTH-1:0] amount_ff;
   logic [FIELD_WIDTH-1:0]        now_ff;

   // configuration registers
   logic [MODULUS_WIDTH-1:0] wrap_modulus_ff, wrap_modulus_in;
   logic [PERIOD_WIDTH-1:0]  step_period_ff, step_period_in;
   logic [JITTER_WIDTH-1:0]  jitter_ff, jitter_in;

   // motor state
   logic [PHASE_WIDTH-1:0]   phase_ff, phase_in;
   logic [COIL_WIDTH-1:0]    coil_ff, coil_in;
   logic [PositionWidth-1:0] position_ff, position_in;
   logic [PositionWidth-1:0] pending_ff, pending_in;
   logic [TimeWidth-1:0]     due_ff, due_in;

   // per-item working registers
   logic                     taken_ff, taken_in;
   logic [MODULUS_WIDTH-1:0] adj_mag_ff, adj_mag_in;
   logic                     adj_neg_ff, adj_neg_in;

   // response registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COIL_WIDTH-1:0]  rsp_coil_ff;
   logic [FIELD_WIDTH-1:0] rsp_position_ff;
   logic [FIELD_WIDTH-1:0] rsp_steps_ff;
   logic                   rsp_moving_ff;
   logic                   rsp_taken_ff;

   logic req_accept;
   logic csr_accept;
   logic rsp_load;

   // remainder unit hookup
   logic                 div_start;
   logic [DivWidth-1:0]  div_dividend;
   shsp_div_status_type  div_status;

   // datapath terms
   logic [DivWidth-1:0]      amount_div;
   logic [PositionWidth-1:0] amount_pos;
   logic [TimeWidth-1:0]     now_time;
   logic [TimeWidth-1:0]     early_time;
   logic                     pend_zero;
   logic                     pend_neg;
   logic                     pend_last;
   logic                     tick_go;
   logic [PHASE_WIDTH-1:0]   phase_next;
   logic [PositionWidth-1:0] rel_sum;
   logic [PositionWidth-1:0] abs_diff;
   logic                     modulus_zero;
   logic signed [ArithWidth-1:0] pos_ext;
   logic signed [ArithWidth-1:0] mod_ext;
   logic signed [ArithWidth-1:0] pos_plus;
   logic signed [ArithWidth-1:0] pos_minus;
   logic                     wrap_high;
   logic [MODULUS_WIDTH-1:0] half_turn;
   logic                     rem_big;
   logic [MODULUS_WIDTH-1:0] rem_sub;
   logic [DivWidth-1:0]      fix_ext;
   logic [DivWidth-1:0]      fix_val;
   logic [PositionWidth-1:0] fix_pos;
   logic                     cmd_apply;
   logic [PositionWidth-1:0] cmd_steps;

   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign req_stall  = (state_ff != S_IDLE);

   // result may load when the output register is empty or being drained
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // amount sign-extended, then cut to the position width
   assign amount_div = DivWidth'(amount_ff);
   assign amount_pos = amount_div[PositionWidth-1:0];

   // step due when due time minus the allowance is at or before now, modulo time width
   assign now_time   = TimeWidth'(now_ff);
   assign early_time = due_ff - TimeWidth'(jitter_ff);

   assign pend_zero = (pending_ff == '0);
   assign pend_neg  = pending_ff[PositionWidth-1];
   assign pend_last = (pending_ff == PositionWidth'(1)) || (pending_ff == '1);
   assign tick_go   = !pend_zero && (early_time <= now_time);

   // clockwise (positive) walks the table backward
   assign phase_next = pend_neg ? (phase_ff + 3'd1) : (phase_ff - 3'd1);

   assign rel_sum  = pending_ff + amount_pos;
   assign abs_diff = amount_pos - position_ff;

   assign modulus_zero = (wrap_modulus_ff == '0);

   // single correction by one modulus after a step
   assign pos_ext   = ArithWidth'($signed(position_ff));
   assign mod_ext   = ArithWidth'(wrap_modulus_ff);
   assign pos_plus  = pos_ext + mod_ext;
   assign pos_minus = pos_ext - mod_ext;
   assign wrap_high = (pos_ext >= mod_ext);

   // remainder post-processing: pull the signed remainder into half a turn,
   // or into [0, modulus) for set location
   assign half_turn = wrap_modulus_ff >> 1;
   assign rem_big   = (div_status.remainder > half_turn);
   assign rem_sub   = wrap_modulus_ff - div_status.remainder;

   assign fix_ext = DivWidth'(adj_mag_ff);
   assign fix_val = adj_neg_ff ? (DivWidth'(0) - fix_ext) : fix_ext;
   assign fix_pos = fix_val[PositionWidth-1:0];

   // register writes
   always_comb begin
      wrap_modulus_in = wrap_modulus_ff;
      step_period_in  = step_period_ff;
      jitter_in       = jitter_ff;
      if (csr_accept) begin
         case (csr_index)
            CSR_WRAP_MODULUS: wrap_modulus_in = csr_data[MODULUS_WIDTH-1:0];
            CSR_STEP_PERIOD:  step_period_in  = csr_data[PERIOD_WIDTH-1:0];
            CSR_JITTER:       jitter_in       = csr_data[JITTER_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      coil_in      = coil_ff;
      position_in  = position_ff;
      pending_in   = pending_ff;
      due_in       = due_ff;
      taken_in     = taken_ff;
      adj_mag_in   = adj_mag_ff;
      adj_neg_in   = adj_neg_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      cmd_apply    = 1'b0;
      cmd_steps    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            taken_in = 1'b0;
            state_in = S_DONE;
            case (op_ff)
               OP_TICK: begin
                  if (tick_go) begin
                     taken_in    = 1'b1;
                     phase_in    = phase_next;
                     // last step releases the coils
                     coil_in     = pend_last ? '0 : COIL_TABLE[phase_next];
                     position_in = pend_neg ? (position_ff - PositionWidth'(1))
                                            : (position_ff + PositionWidth'(1));
                     pending_in  = pend_neg ? (pending_ff + PositionWidth'(1))
                                            : (pending_ff - PositionWidth'(1));
                     if (!pend_last) begin
                        due_in = due_ff + TimeWidth'(step_period_ff);
                     end
                     state_in = S_WRAP;
                  end
               end
               OP_RELATIVE: begin
                  cmd_apply = 1'b1;
                  cmd_steps = rel_sum;
               end
               OP_ABSOLUTE: begin
                  if (modulus_zero) begin
                     cmd_apply = 1'b1;
                     cmd_steps = abs_diff;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = DivWidth'($signed(abs_diff));
                     state_in     = S_DIV;
                  end
               end
               OP_STOP: begin
                  // one more step in the current direction
                  pending_in = pend_zero ? '0 : (pend_neg ? '1 : PositionWidth'(1));
               end
               OP_SET_LOC: begin
                  if (modulus_zero) begin
                     position_in = amount_pos;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = amount_div;
                     state_in     = S_DIV;
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (op_ff == OP_SET_LOC) begin
               // truncated remainder of a negative value folds up by one modulus
               adj_mag_in = (div_status.neg && (div_status.remainder != '0)) ? rem_sub
                                                                             : div_status.remainder;
               adj_neg_in = 1'b0;
            end else begin
               // shortest way round: beyond half a turn goes the other way
               adj_mag_in = rem_big ? rem_sub : div_status.remainder;
               adj_neg_in = rem_big ? !div_status.neg : div_status.neg;
            end
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (op_ff == OP_SET_LOC) begin
               position_in = fix_pos;
            end else begin
               cmd_apply = 1'b1;
               cmd_steps = fix_pos;
            end
            state_in = S_DONE;
         end
         S_WRAP: begin
            if (!modulus_zero) begin
               if (position_ff[PositionWidth-1]) begin
                  position_in = pos_plus[PositionWidth-1:0];
               end else if (wrap_high) begin
                  position_in = pos_minus[PositionWidth-1:0];
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // move command: motion start schedules now, a cancel releases the coils
      if (cmd_apply) begin
         if (pend_zero && (cmd_steps != '0)) begin
            due_in = now_time;
         end else if (!pend_zero && (cmd_steps == '0)) begin
            coil_in = '0;
         end
         pending_in = cmd_steps;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   shsp_div_unit #(
      .DividendWidth(DivWidth)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (wrap_modulus_ff),
      .status  (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         wrap_modulus_ff <= WRAP_MODULUS_RST;
         step_period_ff  <= STEP_PERIOD_RST;
         jitter_ff       <= JITTER_RST;
         phase_ff        <= '0;
         coil_ff         <= '0;
         position_ff     <= '0;
         pending_ff      <= '0;
         due_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         wrap_modulus_ff <= wrap_modulus_in;
         step_period_ff  <= step_period_in;
         jitter_ff       <= jitter_in;
         phase_ff        <= phase_in;
         coil_ff         <= coil_in;
         position_ff     <= position_in;
         pending_ff      <= pending_in;
         due_ff          <= due_in;
      end
      // payload
      if (req_accept) begin
         op_ff     <= req_operation;
         amount_ff <= req_amount;
         now_ff    <= req_now_us;
      end
      taken_ff   <= taken_in;
      adj_mag_ff <= adj_mag_in;
      adj_neg_ff <= adj_neg_in;
      if (rsp_load) begin
         rsp_coil_ff     <= coil_ff;
         rsp_position_ff <= FIELD_WIDTH'(position_ff);
         rsp_steps_ff    <= FIELD_WIDTH'(pending_ff);
         rsp_moving_ff   <= !pend_zero;
         rsp_taken_ff    <= taken_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coil_drive      = rsp_coil_ff;
   assign rsp_position        = rsp_position_ff;
   assign rsp_steps_remaining = rsp_steps_ff;
   assign rsp_is_moving       = rsp_moving_ff;
   assign rsp_step_taken      = rsp_taken_ff;

endmodule

// ===== hw/rtl/shsp_checker.sv =====
module shsp_checker
   import shsp_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [COIL_WIDTH-1:0]         rsp_coil_drive,
   input logic signed [FIELD_WIDTH-1:0] rsp_position,
   input logic signed [FIELD_WIDTH-1:0] rsp_steps_remaining,
   input logic                          rsp_is_moving,
   input logic                          rsp_step_taken
);

   // one item at a time: an accepted beat closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in progress");

   // a held result keeps its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position)
                                 && $stable(rsp_steps_remaining) && $stable(rsp_coil_drive))
      else $error("stalled result changed");

   // nonzero remaining count means motion
   a_moving_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_steps_remaining != '0) |-> rsp_is_moving)
      else $error("steps remain but not moving");

   // the step that ends a move releases the coils
   a_last_step_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_taken && !rsp_is_moving |-> (rsp_coil_drive == '0))
      else $error("coils energized after final step");

   // coils show off or a half-step pattern only
   a_coil_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_coil_drive == '0) || (rsp_coil_drive == COIL_TABLE[0])
         || (rsp_coil_drive == COIL_TABLE[1]) || (rsp_coil_drive == COIL_TABLE[2])
         || (rsp_coil_drive == COIL_TABLE[3]) || (rsp_coil_drive == COIL_TABLE[4])
         || (rsp_coil_drive == COIL_TABLE[5]) || (rsp_coil_drive == COIL_TABLE[6])
         || (rsp_coil_drive == COIL_TABLE[7]))
      else $error("illegal coil pattern");

endmodule

bind stepper_half_step_positioner_core shsp_checker u_shsp_checker (.*);

// ===== bench/tb.sv =====
import shsp_pkg::*;

// tracks the positioner state and the results it owes, in acceptance order
class positioner_scoreboard;
   typedef struct packed {
      logic [COIL_WIDTH-1:0]  coils;
      logic [FIELD_WIDTH-1:0] position;
      logic [FIELD_WIDTH-1:0] remaining;
      logic                   moving;
      logic                   stepped;
   } motion_result_type;

   logic [MODULUS_WIDTH-1:0] modulus;
   logic [PERIOD_WIDTH-1:0]  period_us;
   logic [JITTER_WIDTH-1:0]  jitter_us;
   logic [PHASE_WIDTH-1:0]   phase;
   logic [FIELD_WIDTH-1:0]   cur_position;
   logic [FIELD_WIDTH-1:0]   pending;
   logic [FIELD_WIDTH-1:0]   due_us;
   logic [COIL_WIDTH-1:0]    coils;
   motion_result_type        expected_q[$];
   int unsigned              failures;
   int unsigned              checked;
   int unsigned              steps_dispatched;

   function new();
      modulus          = WRAP_MODULUS_RST;
      period_us        = STEP_PERIOD_RST;
      jitter_us        = JITTER_RST;
      phase            = '0;
      cur_position     = '0;
      pending          = '0;
      due_us           = '0;
      coils            = '0;
      failures         = 0;
      checked          = 0;
      steps_dispatched = 0;
   endfunction

   function int unsigned outstanding();
      return expected_q.size();
   endfunction

   function void write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_WRAP_MODULUS: modulus   = data[MODULUS_WIDTH-1:0];
         CSR_STEP_PERIOD:  period_us = data[PERIOD_WIDTH-1:0];
         CSR_JITTER:       jitter_us = data[JITTER_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   function logic [COIL_WIDTH-1:0] half_step_pattern(logic [PHASE_WIDTH-1:0] idx);
      case (idx)
         3'd0: return 4'b0001;
         3'd1: return 4'b1001;
         3'd2: return 4'b1000;
         3'd3: return 4'b1100;
         3'd4: return 4'b0100;
         3'd5: return 4'b0110;
         3'd6: return 4'b0010;
         default: return 4'b0011;
      endcase
   endfunction

   function void note_request(logic [OP_WIDTH-1:0] op, logic signed [FIELD_WIDTH-1:0] amount,
                              logic [FIELD_WIDTH-1:0] now_us);
      longint                 span;
      longint                 s;
      logic [FIELD_WIDTH-1:0] early;
      logic [FIELD_WIDTH-1:0] target;
      logic                   stepped;
      motion_result_type      r;
      span    = longint'(modulus);
      stepped = 1'b0;
      case (op)
         OP_TICK: begin
            early = due_us - jitter_us;
            if (pending != 0 && early <= now_us) begin
               stepped = 1'b1;
               steps_dispatched++;
               phase = pending[FIELD_WIDTH-1] ? phase + 3'd1 : phase - 3'd1;
               coils = (pending == 1 || pending == '1) ? '0 : half_step_pattern(phase);
               cur_position = pending[FIELD_WIDTH-1] ? cur_position - 1 : cur_position + 1;
               if (span != 0) begin
                  s = longint'($signed(cur_position));
                  if (s < 0) s += span;
                  else if (s >= span) s -= span;
                  cur_position = s[FIELD_WIDTH-1:0];
               end
               pending = pending[FIELD_WIDTH-1] ? pending + 1 : pending - 1;
               if (pending != 0) due_us = due_us + period_us;
            end
         end
         OP_RELATIVE, OP_ABSOLUTE: begin
            if (op == OP_ABSOLUTE) begin
               target = amount - cur_position;
               if (span != 0) begin
                  s = longint'($signed(target)) % span;
                  if (s > span / 2) s -= span;
                  else if (s < -(span / 2)) s += span;
                  target = s[FIELD_WIDTH-1:0];
               end
            end else begin
               target = pending + amount;
            end
            if (pending == 0 && target != 0) due_us = now_us;
            else if (pending != 0 && target == 0) coils = '0;
            pending = target;
         end
         OP_STOP: begin
            if (pending != 0) pending = pending[FIELD_WIDTH-1] ? '1 : 1;
         end
         OP_SET_LOC: begin
            s = longint'(amount);
            if (span != 0) begin
               s = s % span;
               if (s < 0) s += span;
            end
            cur_position = s[FIELD_WIDTH-1:0];
         end
         default: ;
      endcase
      r.coils     = coils;
      r.position  = cur_position;
      r.remaining = pending;
      r.moving    = (pending != 0);
      r.stepped   = stepped;
      expected_q.push_back(r);
   endfunction

   function void compare_field(string field, logic [FIELD_WIDTH-1:0] want,
                               logic [FIELD_WIDTH-1:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
      end
   endfunction

   function void check_response(logic [COIL_WIDTH-1:0] coil_drive,
                                logic [FIELD_WIDTH-1:0] position,
                                logic [FIELD_WIDTH-1:0] remaining,
                                logic moving, logic stepped);
      motion_result_type want;
      checked++;
      if (expected_q.size() == 0) begin
         failures++;
         $display("%0t: unexpected result, expected none got coils %h position %0h steps %0h",
                  $time, coil_drive, position, remaining);
         return;
      end
      want = expected_q.pop_front();
      compare_field("coil_drive", want.coils, coil_drive);
      compare_field("position", want.position, position);
      compare_field("steps_remaining", want.remaining, remaining);
      compare_field("is_moving", want.moving, moving);
      compare_field("step_taken", want.stepped, stepped);
   endfunction
endclass

module tb;
   import shsp_pkg::*;

   // run bounds
   localparam int unsigned LIMIT_CYCLES      = 1000000;
   localparam int unsigned ITEMS_PER_SETTING = 232;
   localparam int unsigned NUM_SETTINGS      = 8;

   // codes the block must ignore
   localparam logic [OP_WIDTH-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_SPARE_7 = 3'd7;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [OP_WIDTH-1:0]           req_operation = OP_TICK;
   logic signed [FIELD_WIDTH-1:0] req_amount = '0;
   logic [FIELD_WIDTH-1:0]        req_now_us = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [COIL_WIDTH-1:0]         rsp_coil_drive;
   logic signed [FIELD_WIDTH-1:0] rsp_position;
   logic signed [FIELD_WIDTH-1:0] rsp_steps_remaining;
   logic                          rsp_is_moving;
   logic                          rsp_step_taken;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = CSR_WRAP_MODULUS;
   logic [CSR_DATA_WIDTH-1:0]     csr_data = '0;

   positioner_scoreboard sb;
   int unsigned          items_sent = 0;
   int unsigned          cycle_count = 0;
   int unsigned          settings_done = 0;
   bit                   no_idle = 1'b0;

   stepper_half_step_positioner_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_amount          (req_amount),
      .req_now_us          (req_now_us),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_coil_drive      (rsp_coil_drive),
      .rsp_position        (rsp_position),
      .rsp_steps_remaining (rsp_steps_remaining),
      .rsp_is_moving       (rsp_is_moving),
      .rsp_step_taken      (rsp_step_taken),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog, covers a hung handshake as well as a missing result
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one request beat; entered and left at a falling edge, valid stays up for back-to-back
   task automatic send_request(input logic [OP_WIDTH-1:0] op,
                               input logic signed [FIELD_WIDTH-1:0] amount,
                               input logic [FIELD_WIDTH-1:0] now_us);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_amount    <= amount;
      req_now_us    <= now_us;
      // beat is taken at the first rising edge without stall
      do @(posedge clock); while (req_stall);
      sb.note_request(op, amount, now_us);
      items_sent++;
      @(negedge clock);
   endtask

   // register write beat; valid is left high so writes can run back to back
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
      @(negedge clock);
   endtask

   task automatic apply_setting(input int unsigned wrap, input int unsigned period_us,
                                input int unsigned jitter_us);
      write_register(CSR_WRAP_MODULUS, CSR_DATA_WIDTH'(wrap));
      write_register(CSR_STEP_PERIOD, CSR_DATA_WIDTH'(period_us));
      write_register(CSR_JITTER, CSR_DATA_WIDTH'(jitter_us));
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // stop sending and let every owed result come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      // step ticks also pass through the wrap state
      repeat (4) @(negedge clock);
   endtask

   // tick time aimed around the earliest dispatch point
   function automatic logic [FIELD_WIDTH-1:0] tick_time();
      case ($urandom_range(0, 9))
         0: return sb.due_us - sb.jitter_us - 1;
         1: return sb.due_us - sb.jitter_us;
         2: return $urandom;
         default: return sb.due_us + $urandom_range(0, 3);
      endcase
   endfunction

   // a command followed by a run of ticks, with the odd interruption
   task automatic run_move();
      int                            delta;
      int                            count;
      logic signed [FIELD_WIDTH-1:0] here;
      // keep runaway moves short
      if ($signed(sb.pending) > 200 || $signed(sb.pending) < -200)
         send_request(OP_STOP, $urandom, $urandom);
      here  = sb.cur_position;
      delta = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: send_request(OP_RELATIVE, $urandom_range(0, 1) ? delta : -delta, $urandom);
         5, 6: send_request(OP_ABSOLUTE, here + int'($urandom_range(0, 80)) - 40, $urandom);
         7: begin
            if (sb.modulus != 0)
               send_request(OP_ABSOLUTE, $urandom_range(0, sb.modulus - 1), $urandom);
            else
               send_request(OP_ABSOLUTE, $urandom, $urandom);
         end
         8: begin
            send_request(OP_SET_LOC, $urandom, $urandom);
            send_request(OP_RELATIVE, -delta, $urandom);
         end
         default: send_request(OP_RELATIVE, $urandom, $urandom);
      endcase
      count = $urandom_range(1, 16);
      repeat (count) begin
         case ($urandom_range(0, 19))
            0: send_request(OP_STOP, $urandom, $urandom);
            // absolute move onto the current spot ends the move by command
            1: send_request(OP_ABSOLUTE, sb.cur_position, $urandom);
            2: send_request(OP_SET_LOC, int'($urandom_range(0, 300)) - 20, $urandom);
            default: send_request(OP_TICK, $urandom, tick_time());
         endcase
      end
   endtask

   // hand-picked beats at the reset register values
   task automatic directed_defaults();
      send_request(OP_TICK, 0, 0);                          // nothing to do
      send_request(OP_SPARE_5, 32'h7fff_ffff, 32'hffff_ffff);
      send_request(OP_SPARE_6, 32'h8000_0000, 0);
      send_request(OP_SPARE_7, -1, 32'h5555_5555);
      send_request(OP_SET_LOC, -5, 0);                      // negative location folds up
      send_request(OP_SET_LOC, 32'h7fff_ffff, 0);
      send_request(OP_SET_LOC, 32'h8000_0000, 0);
      send_request(OP_RELATIVE, 3, 100);                    // motion starts, due at 100
      send_request(OP_TICK, 0, 100);
      send_request(OP_TICK, 0, 101);                        // not due, coils hold
      send_request(OP_TICK, 0, 2100);
      send_request(OP_TICK, 0, 4100);                       // last step, coils off
      send_request(OP_SET_LOC, 1, 0);
      send_request(OP_RELATIVE, -2, 9000);
      send_request(OP_TICK, 0, 9000);
      send_request(OP_TICK, 0, 11000);                      // wraps below zero
      send_request(OP_RELATIVE, 1, 12000);
      send_request(OP_ABSOLUTE, 32'h7fff_ffff, 32'hffff_ffff); // cancels, coils off
      send_request(OP_ABSOLUTE, 32'h8000_0000, 32'hffff_fff0);
      send_request(OP_STOP, 0, 0);
      send_request(OP_SET_LOC, 0, 0);
      send_request(OP_ABSOLUTE, 3000, 0);                   // shorter the other way round
      send_request(OP_ABSOLUTE, -3000, 0);
      send_request(OP_RELATIVE, 32'h7fff_ffff, 0);
      send_request(OP_RELATIVE, 32'h7fff_ffff, 0);          // pending count overflows
      send_request(OP_STOP, 0, 0);
   endtask

   // linear position crossing the top of the signed range
   task automatic directed_linear();
      send_request(OP_SET_LOC, 32'h7fff_ffff, 0);
      send_request(OP_RELATIVE, 2, 500);
      send_request(OP_TICK, 0, sb.due_us);
      send_request(OP_TICK, 0, sb.due_us);
   endtask

   // result side: random stall per beat, checks every accepted beat
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 8);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_coil_drive, rsp_position, rsp_steps_remaining,
                           rsp_is_moving, rsp_step_taken);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      int unsigned wrap_list[NUM_SETTINGS]   = '{4096, 0, 200, 1, 2147483647, 7, 48, 0};
      int unsigned period_list[NUM_SETTINGS] = '{2000, 1, 1000000, 50, 300, 1, 1000, 20};
      int unsigned jitter_list[NUM_SETTINGS] = '{0, 0, 65535, 10, 0, 65535, 500, 3};
      int unsigned stop_at;
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < NUM_SETTINGS; k++) begin
         wait_until_drained();
         // location is deliberately kept across settings, so it may sit outside a new modulus
         apply_setting(wrap_list[k], period_list[k], jitter_list[k]);
         no_idle = 1'b0;
         if (k == 0) directed_defaults();
         if (k == 1) directed_linear();
         stop_at = items_sent + ITEMS_PER_SETTING;
         while (items_sent < stop_at) begin
            // some stretches run with neither side idling
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) == 0)
               send_request(OP_WIDTH'($urandom_range(0, 7)), $urandom, $urandom);
            else
               run_move();
         end
      end

      wait_until_drained();
      repeat (50) @(posedge clock);
      $display("%0d request beats over %0d register settings, %0d steps dispatched",
               items_sent, settings_done, sb.steps_dispatched);
      $display("%0d result beats checked, %0d mismatches", sb.checked, sb.failures);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/shsp_pkg.sv
hw/rtl/shsp_div_unit.sv
hw/rtl/stepper_half_step_positioner_core.sv
hw/rtl/shsp_checker.sv
bench/tb.sv
